FILE: design/mbe_pkg.sv
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants of the escape-time core
// Payload words, the multiplier chain word, sequencer states and band limits.
// ----------------------------------------------------------------------------
package mbe_pkg;

    typedef struct packed {
        logic signed [63:0] point_real;
        logic signed [63:0] point_imag;
    } point_t;

    typedef struct packed {
        logic [6:0] escape_count;
        logic [3:0] colour_band;
    } result_t;

    typedef enum logic [1:0] {
        TAG_RSQ   = 2'd0,
        TAG_ISQ   = 2'd1,
        TAG_CROSS = 2'd2
    } prod_tag_t;

    typedef struct packed {
        logic         vld;
        prod_tag_t    tag;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [127:0] acc;
    } mul_word_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FEED = 2'd1,
        S_WAIT = 2'd2,
        S_STEP = 2'd3
    } seq_state_t;

    localparam int NUM_LIMITS = 11;
    localparam int NUM_CELLS  = 4;
    localparam logic [3:0] BAND_BLANK  = 4'd0;
    localparam logic [3:0] BAND_LOWEST = 4'd12;

    localparam logic [6:0] NORMAL_LIMITS [NUM_LIMITS] =
        '{7'd90, 7'd70, 7'd50, 7'd30, 7'd20, 7'd10, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1};
    localparam logic [6:0] DEEP_LIMITS [NUM_LIMITS] =
        '{7'd99, 7'd98, 7'd96, 7'd94, 7'd92, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd60};

    // signed add clamped to the 64-bit range
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

endpackage

FILE: design/mbe_mul_cell.sv
// ----------------------------------------------------------------------------
// mbe_mul_cell: one cell of the 64x64 multiplier chain
// Multiplies one 32-bit half of each operand, adds it at its weight to the
// running product and hands the word on to the next cell.
// ----------------------------------------------------------------------------
module mbe_mul_cell #(
    parameter bit A_HI  = 1'b0,
    parameter bit B_HI  = 1'b0,
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mbe_pkg::mul_word_t word_in,
    output mbe_pkg::mul_word_t word_out
);

    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  part;
    logic [127:0] acc_next;
    logic         vld_reg;
    mbe_pkg::mul_word_t word_reg;

    always_comb
    begin
        a_half   = A_HI ? word_in.a[63:32] : word_in.a[31:0];
        b_half   = B_HI ? word_in.b[63:32] : word_in.b[31:0];
        part     = 64'(a_half) * 64'(b_half);
        acc_next = word_in.acc + (128'(part) << SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= word_in.vld;
    end

    always_ff @(posedge clk)
    begin
        word_reg.tag <= word_in.tag;
        word_reg.a   <= word_in.a;
        word_reg.b   <= word_in.b;
        word_reg.acc <= acc_next;
    end

    always_comb
    begin
        word_out.vld = vld_reg;
        word_out.tag = word_reg.tag;
        word_out.a   = word_reg.a;
        word_out.b   = word_reg.b;
        word_out.acc = word_reg.acc;
    end

endmodule

FILE: design/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core: escape-time iteration with colour banding
// Iterates z = z*z + c from z = c and reports the escape count and band.
// ----------------------------------------------------------------------------
// usage
//   start/point: a point is taken at a clock edge with start high and busy
//   low. busy stays high until the result word is given.
//   done/result: one word per point, valid for exactly one cycle while done
//   is high; the receiver cannot hold it off.
//   cfg_valid/cfg_ready/cfg_data: band table select, bit 0 picks the deep
//   thresholds; write it only while busy is low. ready is always high.
// iteration
//   each iteration streams three 64x64 products through a four-cell chain
//   of 32x32 multipliers: the real square, imaginary square and cross
//   product are fed in turn, the sequencer waits for the cross product to
//   leave the chain, and an update state then tests for escape and steps z.
// reset
//   reset returns the sequencer to idle and clears the band select.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core #(
    parameter int MAX_ITER  = 100,
    parameter int FRAC_BITS = 60
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mbe_pkg::point_t  point,
    output logic             done,
    output mbe_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);

    localparam int NW = $clog2(MAX_ITER + 1);
    localparam logic [127:0] THRESH = 128'd1 << (2 * FRAC_BITS + 2);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_ITER);

    mbe_pkg::seq_state_t state_reg, state_next;
    logic [1:0]    feed_reg, feed_next;
    logic [NW-1:0] n_reg, n_next;
    logic          band_sel_reg;
    logic          done_reg, done_next;
    logic [NW-1:0] fin_n;

    logic [63:0]  cr_reg, ci_reg, zr_reg, zi_reg;
    logic [63:0]  zr_next, zi_next;
    logic [127:0] rsq_reg, isq_reg, psq_reg;
    logic [6:0]   count_reg;
    logic [3:0]   band_reg;
    logic         load_point, load_z, load_result;

    logic [63:0]  mr, mi;
    logic [127:0] mag_sum;
    logic         escaped;
    logic [63:0]  re_sq, im_sq, prod, cross_term, diff;
    logic [3:0]   band_calc;

    mbe_pkg::mul_word_t feed_word;
    mbe_pkg::mul_word_t chain [mbe_pkg::NUM_CELLS+1];

    assign chain[0] = feed_word;

    // multiplier chain
    for (genvar i = 0; i < mbe_pkg::NUM_CELLS; i++)
    begin : g_cell
        mbe_mul_cell #(
            .A_HI (i >= 2),
            .B_HI (i == 1 || i == 3),
            .SHIFT(i == 0 ? 0 : (i == 3 ? 64 : 32))
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .word_in (chain[i]),
            .word_out(chain[i+1])
        );
    end

    always_comb
    begin
        mr = zr_reg[63] ? 64'd0 - zr_reg : zr_reg;
        mi = zi_reg[63] ? 64'd0 - zi_reg : zi_reg;
        feed_word.vld = (state_reg == mbe_pkg::S_FEED);
        feed_word.acc = '0;
        case (feed_reg)
            2'd0:
            begin
                feed_word.tag = mbe_pkg::TAG_RSQ;
                feed_word.a   = mr;
                feed_word.b   = mr;
            end
            2'd1:
            begin
                feed_word.tag = mbe_pkg::TAG_ISQ;
                feed_word.a   = mi;
                feed_word.b   = mi;
            end
            default:
            begin
                feed_word.tag = mbe_pkg::TAG_CROSS;
                feed_word.a   = mr;
                feed_word.b   = mi;
            end
        endcase
    end

    // escape test and next z
    always_comb
    begin
        mag_sum    = rsq_reg + isq_reg;
        escaped    = mag_sum > THRESH;
        re_sq      = rsq_reg[FRAC_BITS +: 64];
        im_sq      = isq_reg[FRAC_BITS +: 64];
        prod       = psq_reg[FRAC_BITS-1 +: 64];
        cross_term = (zr_reg[63] ^ zi_reg[63]) ? 64'd0 - prod : prod;
        diff       = re_sq - im_sq;
        zr_next    = mbe_pkg::sat_add(diff, cr_reg);
        zi_next    = mbe_pkg::sat_add(cross_term, ci_reg);
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        feed_next   = feed_reg;
        n_next      = n_reg;
        done_next   = 1'b0;
        load_point  = 1'b0;
        load_z      = 1'b0;
        load_result = 1'b0;
        fin_n       = n_reg;
        case (state_reg)
            mbe_pkg::S_IDLE:
            begin
                if (start)
                begin
                    load_point = 1'b1;
                    n_next     = '0;
                    feed_next  = 2'd0;
                    state_next = mbe_pkg::S_FEED;
                end
            end
            mbe_pkg::S_FEED:
            begin
                feed_next = feed_reg + 2'd1;
                if (feed_reg == 2'd2)
                    state_next = mbe_pkg::S_WAIT;
            end
            mbe_pkg::S_WAIT:
            begin
                if (chain[mbe_pkg::NUM_CELLS].vld &&
                    chain[mbe_pkg::NUM_CELLS].tag == mbe_pkg::TAG_CROSS)
                    state_next = mbe_pkg::S_STEP;
            end
            mbe_pkg::S_STEP:
            begin
                if (escaped)
                begin
                    fin_n       = n_reg;
                    load_result = 1'b1;
                    done_next   = 1'b1;
                    state_next  = mbe_pkg::S_IDLE;
                end
                else if (n_reg + NW'(1) == N_MAX)
                begin
                    fin_n       = N_MAX;
                    load_result = 1'b1;
                    done_next   = 1'b1;
                    state_next  = mbe_pkg::S_IDLE;
                end
                else
                begin
                    load_z     = 1'b1;
                    n_next     = n_reg + NW'(1);
                    feed_next  = 2'd0;
                    state_next = mbe_pkg::S_FEED;
                end
            end
            default:
            begin
                state_next = mbe_pkg::S_IDLE;
            end
        endcase
    end

    // band lookup, first matching threshold wins
    always_comb
    begin
        band_calc = mbe_pkg::BAND_LOWEST;
        for (int k = mbe_pkg::NUM_LIMITS - 1; k >= 0; k--)
        begin
            if (band_sel_reg)
            begin
                if (13'(fin_n) >= 13'(mbe_pkg::DEEP_LIMITS[k]))
                    band_calc = 4'(k + 1);
            end
            else
            begin
                if (13'(fin_n) > 13'(mbe_pkg::NORMAL_LIMITS[k]))
                    band_calc = 4'(k + 1);
            end
        end
        if (fin_n == N_MAX)
            band_calc = mbe_pkg::BAND_BLANK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mbe_pkg::S_IDLE;
            feed_reg     <= 2'd0;
            n_reg        <= '0;
            done_reg     <= 1'b0;
            band_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            feed_reg  <= feed_next;
            n_reg     <= n_next;
            done_reg  <= done_next;
            if (cfg_valid)
                band_sel_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_point)
        begin
            cr_reg <= point.point_real;
            ci_reg <= point.point_imag;
            zr_reg <= point.point_real;
            zi_reg <= point.point_imag;
        end
        else if (load_z)
        begin
            zr_reg <= zr_next;
            zi_reg <= zi_next;
        end
        if (chain[mbe_pkg::NUM_CELLS].vld)
        begin
            case (chain[mbe_pkg::NUM_CELLS].tag)
                mbe_pkg::TAG_RSQ:   rsq_reg <= chain[mbe_pkg::NUM_CELLS].acc;
                mbe_pkg::TAG_ISQ:   isq_reg <= chain[mbe_pkg::NUM_CELLS].acc;
                default:            psq_reg <= chain[mbe_pkg::NUM_CELLS].acc;
            endcase
        end
        if (load_result)
        begin
            count_reg <= 7'(fin_n);
            band_reg  <= band_calc;
        end
    end

    assign busy                = (state_reg != mbe_pkg::S_IDLE);
    assign cfg_ready           = 1'b1;
    assign done                = done_reg;
    assign result.escape_count = count_reg;
    assign result.colour_band  = band_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word while still busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("point taken but core not busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a point in flight");
    a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.colour_band <= mbe_pkg::BAND_LOWEST)
        else $error("colour band out of range");
`endif

endmodule

FILE: tb/mandelbrot_escape_time_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_checker: escape count and band predictor
// Watches the point, result and band select channels of the core, predicts
// each result word from the accepted point and compares it in order.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_checker #(
    parameter int MAX_ITER  = 100,
    parameter int FRAC_BITS = 60
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  mbe_pkg::point_t  point,
    input  logic             done,
    input  mbe_pkg::result_t result,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam logic [6:0] NORMAL_EDGE [11] =
        '{7'd90, 7'd70, 7'd50, 7'd30, 7'd20, 7'd10, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1};
    localparam logic [6:0] DEEP_EDGE [11] =
        '{7'd99, 7'd98, 7'd96, 7'd94, 7'd92, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70, 7'd60};

    mbe_pkg::result_t expected_words[$];
    logic             deep_sel;

    function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7fff_ffff_ffff_ffff)
            return 64'sh7fff_ffff_ffff_ffff;
        if (s < -65'sh0_8000_0000_0000_0000)
            return 64'sh8000_0000_0000_0000;
        return s[63:0];
    endfunction

    function automatic int escape_steps(input logic signed [63:0] cr,
                                        input logic signed [63:0] ci);
        logic signed [63:0] zr, zi, cross_term;
        logic [63:0]  mr, mi, re_sq, im_sq;
        logic [127:0] rsq, isq, pr;
        logic [128:0] mag, lim;
        zr = cr;
        zi = ci;
        lim = 129'd1 << (2 * FRAC_BITS + 2);
        for (int n = 0; n < MAX_ITER; n++)
        begin
            mr = zr[63] ? -zr : zr;
            mi = zi[63] ? -zi : zi;
            rsq = {64'd0, mr} * {64'd0, mr};
            isq = {64'd0, mi} * {64'd0, mi};
            mag = {1'b0, rsq} + {1'b0, isq};
            if (mag > lim)
                return n;
            re_sq = rsq[FRAC_BITS +: 64];
            im_sq = isq[FRAC_BITS +: 64];
            pr = {64'd0, mr} * {64'd0, mi};
            cross_term = pr[FRAC_BITS-1 +: 64];
            if (zr[63] != zi[63])
                cross_term = -cross_term;
            zi = clamp_add(cross_term, ci);
            zr = clamp_add(re_sq - im_sq, cr);
        end
        return MAX_ITER;
    endfunction

    function automatic logic [3:0] band_for(input int n, input logic deep);
        if (n == MAX_ITER)
            return 4'd0;
        for (int k = 0; k < 11; k++)
        begin
            if (deep ? (n >= int'(DEEP_EDGE[k])) : (n > int'(NORMAL_EDGE[k])))
                return 4'(k + 1);
        end
        return 4'd12;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mbe_pkg::result_t exp_w;
        int               n;
        if (!rst_n)
        begin
            deep_sel   <= 1'b0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                deep_sel <= cfg_data;
            if (start && !busy)
            begin
                n = escape_steps(point.point_real, point.point_imag);
                exp_w.escape_count = 7'(n);
                exp_w.colour_band  = band_for(n, deep_sel);
                expected_words.push_back(exp_w);
            end
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word count=%0d band=%0d",
                                 result.escape_count, result.colour_band);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (exp_w !== result)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: count exp %0d got %0d, band exp %0d got %0d",
                                     exp_w.escape_count, result.escape_count,
                                     exp_w.colour_band, result.colour_band);
                    end
                end
            end
        end
        pending = expected_words.size();
    end

endmodule

FILE: tb/mandelbrot_escape_time_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core_tb: stimulus and verdict for the core
// Drives directed and random points under both band tables with random
// start gaps; a checker beside the core predicts and compares every word.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core_tb;

    localparam logic signed [63:0] ONE = 64'sd1 <<< 60;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    mbe_pkg::point_t  point;
    logic             done;
    mbe_pkg::result_t result;
    logic             cfg_valid;
    logic             cfg_ready;
    logic             cfg_data;
    int               fail_count;
    int               pending;

    mandelbrot_escape_time_core u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    mandelbrot_escape_time_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_point(input logic signed [63:0] re, input logic signed [63:0] im,
                              input bit allow_gap);
        if (allow_gap && $urandom_range(0, 2) == 0)
        begin
            // let the core go idle, then hold start low for a random gap
            start = 1'b0;
            while (busy)
                @(negedge clk);
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        start = 1'b1;
        point.point_real = re;
        point.point_imag = im;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic write_band_sel(input logic deep);
        while (pending != 0 || busy)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = deep;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly points near the set edge so counts spread over every band
    task automatic random_point(input bit allow_gap);
        logic signed [63:0] re, im;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
        begin
            re = rand64();
            im = rand64();
        end
        else if (pick < 7)
        begin
            re = $signed(rand64()) >>> 2;
            im = $signed(rand64()) >>> 2;
        end
        else
        begin
            // neck of the set at -0.75: count grows as imag shrinks
            re = -(ONE >>> 1) - (ONE >>> 2) + ($signed(rand64()) >>> 12);
            im = 64'($urandom_range(0, 32'h3ff_ffff)) << 20;
            if ($urandom_range(0, 1))
                im = -im;
        end
        send_point(re, im, allow_gap);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        point     = '0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, origin, edge of the disc, bounded and quick escapes
        send_point(64'sh7fff_ffff_ffff_ffff, 64'sh7fff_ffff_ffff_ffff, 1'b0);
        send_point(64'sh8000_0000_0000_0000, 64'sh8000_0000_0000_0000, 1'b0);
        send_point(64'sh8000_0000_0000_0000, 64'sd0, 1'b0);
        send_point(64'sd0, 64'sd0, 1'b0);
        send_point(-(ONE <<< 1), 64'sd0, 1'b0);
        send_point(ONE <<< 1, 64'sd0, 1'b0);
        send_point(ONE, 64'sd0, 1'b0);
        send_point(ONE >>> 2, 64'sd0, 1'b0);
        send_point((ONE >>> 2) + 64'sd1, 64'sd0, 1'b0);
        send_point(64'sd0, ONE, 1'b0);
        send_point(-ONE, 64'sd1, 1'b0);
        send_point(-(ONE >>> 2) * 3, ONE >>> 5, 1'b1);
        send_point(-(ONE >>> 2) * 3, ONE >>> 7, 1'b1);
        send_point(-64'sd1, -64'sd1, 1'b1);
        write_band_sel(1'b1);
        send_point(-(ONE >>> 2) * 3, ONE >>> 5, 1'b0);
        send_point(-(ONE >>> 2) * 3, ONE >>> 6, 1'b0);
        send_point(-(ONE >>> 2) * 3, (ONE >>> 6) + (ONE >>> 8), 1'b0);
        send_point(-ONE, 64'sd1, 1'b0);
        send_point(ONE, ONE, 1'b0);

        for (int phase = 0; phase < 6; phase++)
        begin
            write_band_sel(phase == 5 ? 1'b1 : logic'(phase % 2));
            for (int i = 0; i < 300; i++)
                random_point(phase < 5);
        end

        while (pending != 0)
            @(negedge clk);
        repeat (1000) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
